// ----- rtl/lease_expiry_table_macros.svh -----
// Assertion macros for the lease expiry table.
`ifndef LEASE_EXPIRY_TABLE_MACROS_SVH
`define LEASE_EXPIRY_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
`define LXT_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("lease expiry table assertion failed");
`define LXT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lease expiry table assertion failed");
`else
`define LXT_ASSERT(lbl, clk, rst, prop)
`define LXT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/lxt_pkg.sv -----
package lxt_pkg;

  localparam int TOKENS   = 64;
  localparam int KEY_BITS = 16;

  localparam int OP_W      = 2;
  localparam int KEY_IN_W  = 16;
  localparam int TIME_W    = 32;
  localparam int LIFE_W    = 31;
  localparam int EXP_W     = 33;
  localparam int COUNT_W   = 7;
  localparam int STATUS_W  = 2;
  localparam int COUNT_MAX = 127;

  localparam int IN_W      = OP_W + KEY_IN_W + TIME_W;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W     = COUNT_W + STATUS_W;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int IDX_W = $clog2(TOKENS);
  localparam int CNT_W = $clog2(TOKENS + 1);
  localparam int RAM_W = KEY_BITS + EXP_W;

  typedef enum logic [OP_W-1:0] {
    OP_GENERATE = 2'd0,
    OP_RENEW    = 2'd1,
    OP_COUNT    = 2'd2,
    OP_SPARE    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic out_hold;
  } stat_t;

endpackage

// ----- rtl/lxt_ram.sv -----
module lxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/lxt_ctrl.sv -----
`include "lease_expiry_table_macros.svh"

module lxt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lxt_pkg::stat_t stat,
  output lxt_pkg::cmd_t  cmd
);

  lxt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lxt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      lxt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = lxt_pkg::S_ISSUE;
        end
      end
      lxt_pkg::S_ISSUE: begin
        cmd.issue = 1'b1;
        if (stat.issue_last) begin
          state_next = lxt_pkg::S_DRAIN;
        end
      end
      lxt_pkg::S_DRAIN: begin
        state_next = lxt_pkg::S_FINISH;
      end
      lxt_pkg::S_FINISH: begin
        if (!stat.out_hold) begin
          cmd.finish = 1'b1;
          state_next = lxt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lxt_pkg::S_IDLE;
      end
    endcase
  end

  `LXT_ASSERT(a_load_starts_scan, clk, rst, cmd.load |=> state == lxt_pkg::S_ISSUE)
  `LXT_ASSERT(a_last_issue_drains, clk, rst,
              cmd.issue && stat.issue_last |=> state == lxt_pkg::S_DRAIN)
  `LXT_ASSERT(a_finish_not_held, clk, rst, cmd.finish |-> !stat.out_hold)

endmodule

// ----- rtl/lxt_dpath.sv -----
`include "lease_expiry_table_macros.svh"

module lxt_dpath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lxt_pkg::LIFE_W-1:0]      cfg_data,
  input  logic [lxt_pkg::IN_DATA_W-1:0]   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lxt_pkg::OUT_DATA_W-1:0]  out_data,
  input  lxt_pkg::cmd_t                   cmd,
  output lxt_pkg::stat_t                  stat
);

  localparam int IDX_W = lxt_pkg::IDX_W;
  localparam int CNT_W = lxt_pkg::CNT_W;
  localparam int KB    = lxt_pkg::KEY_BITS;
  localparam int EXP_W = lxt_pkg::EXP_W;

  logic [lxt_pkg::LIFE_W-1:0]   lifetime;
  logic [lxt_pkg::OP_W-1:0]     op;
  logic [KB-1:0]                key;
  logic [lxt_pkg::TIME_W-1:0]   now;
  logic [EXP_W-1:0]             expiry;
  logic [IDX_W-1:0]             scan_idx;
  logic                         eval_en;
  logic [IDX_W-1:0]             eval_idx;
  logic                         hit_found;
  logic [IDX_W-1:0]             hit_idx;
  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;
  logic [lxt_pkg::TOKENS-1:0]   valid_bits;
  logic [CNT_W-1:0]             live_total;
  logic [CNT_W-1:0]             live_total_next;
  logic [lxt_pkg::COUNT_W-1:0]  out_count;
  logic [lxt_pkg::STATUS_W-1:0] out_status;

  logic [lxt_pkg::KEY_IN_W-1:0] in_key;
  logic [lxt_pkg::TIME_W-1:0]   in_time;
  logic [lxt_pkg::OP_W-1:0]     in_op;
  logic [lxt_pkg::RAM_W-1:0]    rd_data;
  logic [KB-1:0]                ent_key;
  logic [EXP_W-1:0]             ent_exp;
  logic                         ent_valid;
  logic                         retire;
  logic                         ent_live;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic                         set_valid;
  logic [lxt_pkg::STATUS_W-1:0] status_next;

  assign in_op   = in_data[lxt_pkg::OP_W-1:0];
  assign in_key  = in_data[lxt_pkg::OP_W +: lxt_pkg::KEY_IN_W];
  assign in_time = in_data[lxt_pkg::OP_W + lxt_pkg::KEY_IN_W +: lxt_pkg::TIME_W];

  assign ent_key   = rd_data[KB-1:0];
  assign ent_exp   = rd_data[KB +: EXP_W];
  assign ent_valid = valid_bits[eval_idx];
  assign retire    = eval_en && ent_valid && (ent_exp <= EXP_W'(now));
  assign ent_live  = ent_valid && !retire;

  assign stat.issue_last = (scan_idx == IDX_W'(lxt_pkg::TOKENS - 1));
  assign stat.out_hold   = out_valid && !out_ready;

  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = hit_idx;
    set_valid   = 1'b0;
    status_next = lxt_pkg::ST_DONE;
    case (op)
      lxt_pkg::OP_GENERATE: begin
        if (hit_found) begin
          wr_en = 1'b1;
        end else if (free_found) begin
          wr_en     = 1'b1;
          wr_addr   = free_idx;
          set_valid = 1'b1;
        end else begin
          status_next = lxt_pkg::ST_FULL;
        end
      end
      lxt_pkg::OP_RENEW: begin
        if (hit_found) begin
          wr_en = 1'b1;
        end else begin
          status_next = lxt_pkg::ST_IGNORED;
        end
      end
      default: begin
        status_next = lxt_pkg::ST_DONE;
      end
    endcase
  end

  always_comb begin
    live_total_next = live_total;
    if (retire) begin
      live_total_next = live_total - CNT_W'(1);
    end else if (cmd.finish && set_valid) begin
      live_total_next = live_total + CNT_W'(1);
    end
  end

  lxt_ram #(
    .WIDTH (lxt_pkg::RAM_W),
    .DEPTH (lxt_pkg::TOKENS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.finish && wr_en),
    .wr_addr (wr_addr),
    .wr_data ({expiry, key}),
    .rd_en   (cmd.issue),
    .rd_addr (scan_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lifetime   <= lxt_pkg::LIFE_W'(1);
      eval_en    <= 1'b0;
      valid_bits <= '0;
      live_total <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        lifetime <= cfg_data;
      end
      eval_en    <= cmd.issue;
      live_total <= live_total_next;
      if (retire) begin
        valid_bits[eval_idx] <= 1'b0;
      end
      if (cmd.finish && set_valid) begin
        valid_bits[free_idx] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= scan_idx;
    if (cmd.load) begin
      op         <= in_op;
      key        <= KB'(in_key);
      now        <= in_time;
      expiry     <= EXP_W'(in_time) + EXP_W'(lifetime);
      scan_idx   <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.issue) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (eval_en) begin
      if (ent_live && !hit_found && (ent_key == key)) begin
        hit_found <= 1'b1;
        hit_idx   <= eval_idx;
      end
      if (!ent_live && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= eval_idx;
      end
    end
    if (cmd.finish) begin
      out_status <= status_next;
      if (int'(live_total_next) > lxt_pkg::COUNT_MAX) begin
        out_count <= lxt_pkg::COUNT_W'(lxt_pkg::COUNT_MAX);
      end else begin
        out_count <= lxt_pkg::COUNT_W'(live_total_next);
      end
    end
  end

  assign out_data = lxt_pkg::OUT_DATA_W'({out_status, out_count});

  `LXT_ASSERT(a_live_bounded, clk, rst, int'(live_total) <= lxt_pkg::TOKENS)
  `LXT_ASSERT(a_live_matches_bits, clk, rst,
              int'(live_total) == $countones(valid_bits))
  `LXT_ASSERT(a_retire_only_on_scan, clk, rst, retire |-> !cmd.finish)

endmodule

// ----- rtl/lease_expiry_table.sv -----
// Lease table of 64 entries (valid bit, 16-bit key, 33-bit expiry). Each input beat
// carries an op (0 generate, 1 renew, 2 count), a key and the current time, and gives
// exactly one output beat with the live lease count (saturating at 127) and a status
// (0 done, 1 renew ignored, 2 table full). Keys and expiries sit in a single memory
// that is scanned one entry per cycle to retire expired leases and find the key and
// the lowest free entry, followed by a drain state for the last read and a finish
// state for the write-back. A new item is accepted once the previous one has
// finished; a finished result waits in the output register without stalling the next
// scan. The lifetime register (reset 1) is written through cfg_we/cfg_data; the user
// must write it only while the block is idle, which the block itself does not enforce.
// Valid bits live in flip-flops, so no clearing pass follows reset.
module lease_expiry_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lxt_pkg::LIFE_W-1:0]      cfg_data,      // lease_lifetime
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lxt_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // op, token_key, now
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lxt_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // live_count, status
);

  lxt_pkg::cmd_t  cmd;
  lxt_pkg::stat_t stat;

  lxt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lxt_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
